### design/mseq_pkg.sv
package mseq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int NUM_SOURCES = 4;
	localparam int TAG_BITS    = 16;

	// field widths of the channels
	localparam int SRC_TAG_W = 16;
	localparam int KIND_W    = 3;
	localparam int DATA_W    = 64;
	localparam int OUTQ_W    = 2;

	// derived sizes
	localparam int TAG_W    = (TAG_BITS < SRC_TAG_W) ? TAG_BITS : SRC_TAG_W;
	localparam int STORE_N  = QUEUE_DEPTH * NUM_SOURCES;
	localparam int ADDR_W   = $clog2(STORE_N);
	localparam int PTR_W    = $clog2(QUEUE_DEPTH);
	localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int QIDX_W   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int CLAIM_W  = $clog2(NUM_SOURCES + 1);
	localparam int ENTRY_W  = KIND_W + DATA_W;

	typedef enum logic {
		OP_ENQUEUE = 1'b0,
		OP_FLUSH   = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED   = 3'd0,
		ST_DROP_FULL  = 3'd1,
		ST_NO_QUEUE   = 3'd2,
		ST_EVENT_OUT  = 3'd3,
		ST_NOTHING    = 3'd4
	} status_t;

	typedef enum logic {
		FS_IDLE  = 1'b0,
		FS_DRAIN = 1'b1
	} fsm_t;

	typedef struct packed {
		status_t             status;
		logic [KIND_W-1:0]   kind;
		logic [DATA_W-1:0]   payload;
		logic [OUTQ_W-1:0]   queue;
		logic                last;
	} result_t;

endpackage

### design/mseq_in_if.sv
interface mseq_in_if import mseq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 op;
	logic [SRC_TAG_W-1:0] source_tag;
	logic [KIND_W-1:0]    event_kind;
	logic [DATA_W-1:0]    payload;

	modport source (output valid, op, source_tag, event_kind, payload, input ready);
	modport sink   (input valid, op, source_tag, event_kind, payload, output ready);
endinterface

### design/mseq_out_if.sv
interface mseq_out_if import mseq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [KIND_W-1:0] out_kind;
	logic [DATA_W-1:0] out_payload;
	logic [OUTQ_W-1:0] out_queue;
	logic              last;

	modport source (output valid, status, out_kind, out_payload, out_queue, last, input ready);
	modport sink   (input valid, status, out_kind, out_payload, out_queue, last, output ready);
endinterface

### design/multi_source_event_queue.sv
// Multi-source event queue: per-producer event FIFOs in one shared store.
//
// Channels: evt (sink) takes one word per item: op, source_tag, event_kind,
// payload. res (source) gives result words: status, out_kind, out_payload,
// out_queue, last. Both use valid/ready; a word moves when both are high.
// Enqueue: the tag is matched against the claimed owners, a new tag claims
// the next free queue, and the event is written to the store. One result
// word appears the cycle after acceptance, and enqueues run back to back
// as long as res keeps taking words.
// Flush: the claimed queues are drained in claim order, one store read per
// cycle through the single read port while res keeps taking words; a flush
// of N events gives N words, the final one with last set.
// A flush with nothing stored gives one nothing-pending word.
// No new item is taken until the final word has left the read stage.
// Reset: owners, pointers, fill counts and the claim count clear at once;
// the event store itself is not cleared, since only written entries are
// ever read. No clearing pass is needed.
// Stall: the result register holds while res.ready is low; the drain and
// the input side freeze behind it, and no word is lost or repeated.
module multi_source_event_queue import mseq_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	mseq_in_if.sink       evt,
	mseq_out_if.source    res
);

	// per-queue bookkeeping, small enough for flip-flops
	logic [TAG_W-1:0]   owner_q [NUM_SOURCES];
	logic [PTR_W-1:0]   rptr_q  [NUM_SOURCES];
	logic [FILL_W-1:0]  fill_q  [NUM_SOURCES];
	logic [CLAIM_W-1:0] claimed_q;

	fsm_t state_q, state_d;

	// drain cursor
	logic [QIDX_W-1:0] dq_q;
	logic [PTR_W-1:0]  dj_q;

	// read stage: word in flight from the store
	logic              s1_valid;
	logic [QIDX_W-1:0] s1_queue;
	logic              s1_last;

	// result register
	logic    out_valid_q;
	result_t out_q;

	// store ports
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ENTRY_W-1:0] rd_data;

	logic out_free, s1_move, in_fire;
	logic issue, issue_end;

	// ---------------------------------------------------------------
	// Handshake
	// ---------------------------------------------------------------
	assign out_free  = !out_valid_q || res.ready;
	assign s1_move   = s1_valid && out_free;
	assign evt.ready = (state_q == FS_IDLE) && !s1_valid && out_free;
	assign in_fire   = evt.valid && evt.ready;

	// ---------------------------------------------------------------
	// Enqueue path: tag match, claim, full check, write address
	// ---------------------------------------------------------------
	logic [TAG_W-1:0]  tag;
	logic              hit;
	logic [QIDX_W-1:0] hit_q;
	logic              no_queue;
	logic              claim;
	logic [QIDX_W-1:0] enq_q;
	logic [PTR_W-1:0]  enq_rptr;
	logic [FILL_W-1:0] enq_fill;
	logic              enq_full;
	logic [FILL_W:0]   wr_sum;
	logic [PTR_W-1:0]  wr_off;

	assign tag = evt.source_tag[TAG_W-1:0];

	always_comb begin
		hit   = 1'b0;
		hit_q = '0;
		for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
			if (CLAIM_W'(i) < claimed_q && owner_q[i] == tag) begin
				hit   = 1'b1;
				hit_q = QIDX_W'(i);
			end
		end
	end

	assign no_queue = !hit && (claimed_q >= CLAIM_W'(NUM_SOURCES));
	assign claim    = !hit && !no_queue;
	assign enq_q    = hit ? hit_q : QIDX_W'(claimed_q);
	// a fresh claim starts with an empty queue at offset zero
	assign enq_rptr = claim ? '0 : rptr_q[enq_q];
	assign enq_fill = claim ? '0 : fill_q[enq_q];
	assign enq_full = enq_fill >= FILL_W'(QUEUE_DEPTH);

	// rptr + fill stays below twice the depth: one compare and subtract wraps
	assign wr_sum = (FILL_W + 1)'(enq_rptr) + (FILL_W + 1)'(enq_fill);
	assign wr_off = (wr_sum >= (FILL_W + 1)'(QUEUE_DEPTH))
		? PTR_W'(wr_sum - (FILL_W + 1)'(QUEUE_DEPTH)) : PTR_W'(wr_sum);

	assign wr_en   = in_fire && (evt.op == OP_ENQUEUE) && !no_queue && !enq_full;
	assign wr_addr = ADDR_W'(enq_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wr_off);
	assign wr_data = {evt.event_kind, evt.payload};

	// ---------------------------------------------------------------
	// Drain path: queue scan and read address
	// ---------------------------------------------------------------
	logic [NUM_SOURCES-1:0] nonempty;
	logic                   any_ne;
	logic [QIDX_W-1:0]      first_q;
	logic                   later_ne;
	logic [QIDX_W-1:0]      later_q;
	logic [FILL_W:0]        rd_sum;
	logic [PTR_W-1:0]       rd_off;
	logic [FILL_W:0]        adv_sum;
	logic [PTR_W-1:0]       adv_ptr;

	always_comb begin
		for (int i = 0; i < NUM_SOURCES; i++) begin
			nonempty[i] = (fill_q[i] != '0);
		end
	end

	assign any_ne = |nonempty;

	always_comb begin
		first_q  = '0;
		later_ne = 1'b0;
		later_q  = '0;
		for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
			if (nonempty[i]) begin
				first_q = QIDX_W'(i);
			end
			if (nonempty[i] && QIDX_W'(i) > dq_q) begin
				later_ne = 1'b1;
				later_q  = QIDX_W'(i);
			end
		end
	end

	assign rd_sum = (FILL_W + 1)'(rptr_q[dq_q]) + (FILL_W + 1)'(dj_q);
	assign rd_off = (rd_sum >= (FILL_W + 1)'(QUEUE_DEPTH))
		? PTR_W'(rd_sum - (FILL_W + 1)'(QUEUE_DEPTH)) : PTR_W'(rd_sum);
	assign rd_addr = ADDR_W'(dq_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(rd_off);

	// read pointer after the whole queue is drained
	assign adv_sum = (FILL_W + 1)'(rptr_q[dq_q]) + (FILL_W + 1)'(fill_q[dq_q]);
	assign adv_ptr = (adv_sum >= (FILL_W + 1)'(QUEUE_DEPTH))
		? PTR_W'(adv_sum - (FILL_W + 1)'(QUEUE_DEPTH)) : PTR_W'(adv_sum);

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		issue     = 1'b0;
		issue_end = 1'b0;
		unique case (state_q)
			FS_IDLE: begin
				if (in_fire && evt.op == OP_FLUSH && any_ne) begin
					state_d = FS_DRAIN;
				end
			end
			FS_DRAIN: begin
				// read only when the read stage can hand its word on
				issue     = !s1_valid || s1_move;
				issue_end = (FILL_W'(dj_q) == fill_q[dq_q] - FILL_W'(1));
				if (issue && issue_end && !later_ne) begin
					state_d = FS_IDLE;
				end
			end
			default: state_d = FS_IDLE;
		endcase
	end

	assign rd_en = issue;

	mseq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STORE_N)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// ---------------------------------------------------------------
	// Per-queue state and drain cursor
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SOURCES; i++) begin
				owner_q[i] <= '0;
				rptr_q[i]  <= '0;
				fill_q[i]  <= '0;
			end
			claimed_q <= '0;
			dq_q      <= '0;
			dj_q      <= '0;
		end else begin
			if (in_fire && evt.op == OP_ENQUEUE && !no_queue) begin
				if (claim) begin
					owner_q[enq_q] <= tag;
					rptr_q[enq_q]  <= '0;
					claimed_q      <= claimed_q + CLAIM_W'(1);
				end
				if (!enq_full) begin
					fill_q[enq_q] <= enq_fill + FILL_W'(1);
				end
			end
			if (in_fire && evt.op == OP_FLUSH) begin
				dq_q <= first_q;
				dj_q <= '0;
			end
			if (issue) begin
				if (issue_end) begin
					// queue done: retire its entries, move to the next one
					rptr_q[dq_q] <= adv_ptr;
					fill_q[dq_q] <= '0;
					dq_q         <= later_q;
					dj_q         <= '0;
				end else begin
					dj_q <= dj_q + PTR_W'(1);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Read stage
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (issue) begin
			s1_valid <= 1'b1;
		end else if (s1_move) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			s1_queue <= dq_q;
			s1_last  <= issue_end && !later_ne;
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move || (in_fire && !(evt.op == OP_FLUSH && any_ne))) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q.status  <= ST_EVENT_OUT;
			out_q.kind    <= rd_data[ENTRY_W-1 -: KIND_W];
			out_q.payload <= rd_data[DATA_W-1:0];
			out_q.queue   <= OUTQ_W'(s1_queue);
			out_q.last    <= s1_last;
		end else if (in_fire) begin
			out_q.kind    <= '0;
			out_q.payload <= '0;
			out_q.last    <= 1'b1;
			if (evt.op == OP_FLUSH) begin
				// only the empty flush reports here
				out_q.status <= ST_NOTHING;
				out_q.queue  <= '0;
			end else if (no_queue) begin
				out_q.status <= ST_NO_QUEUE;
				out_q.queue  <= '0;
			end else begin
				out_q.status <= enq_full ? ST_DROP_FULL : ST_ACCEPTED;
				out_q.queue  <= OUTQ_W'(enq_q);
			end
		end
	end

	assign res.valid       = out_valid_q;
	assign res.status      = out_q.status;
	assign res.out_kind    = out_q.kind;
	assign res.out_payload = out_q.payload;
	assign res.out_queue   = out_q.queue;
	assign res.last        = out_q.last;

endmodule

### design/mseq_ram.sv
module mseq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import mseq_pkg::*;

	// Predict the result words of the event queue and hold them until the block
	// hands them out; compare each word that leaves against the oldest one.
	class event_queue_scoreboard;
		logic [KIND_W-1:0] kind_mem [STORE_N];
		logic [DATA_W-1:0] data_mem [STORE_N];
		int unsigned       head     [NUM_SOURCES];
		int unsigned       count    [NUM_SOURCES];
		logic [TAG_W-1:0]  owner    [NUM_SOURCES];
		int unsigned       claimed;
		result_t           expected_words [$];
		int unsigned       mismatches, checked, enqueues, flushes;
		int unsigned       drained, dropped, rejected;

		function new();
			for (int i = 0; i < NUM_SOURCES; i++) begin
				head[i]  = 0;
				count[i] = 0;
				owner[i] = '0;
			end
			claimed    = 0;
			mismatches = 0;
			checked    = 0;
			enqueues   = 0;
			flushes    = 0;
			drained    = 0;
			dropped    = 0;
			rejected   = 0;
		endfunction

		function automatic int unsigned outstanding();
			return expected_words.size();
		endfunction

		function automatic void push_word(status_t st, logic [KIND_W-1:0] kind,
				logic [DATA_W-1:0] data, int q, logic fin);
			result_t r;
			r.status  = st;
			r.kind    = kind;
			r.payload = data;
			r.queue   = q[OUTQ_W-1:0];
			r.last    = fin;
			expected_words.push_back(r);
		endfunction

		// Note one accepted input word and predict the result words it causes.
		function automatic void note_word(op_t op, logic [SRC_TAG_W-1:0] tag,
				logic [KIND_W-1:0] kind, logic [DATA_W-1:0] data);
			logic [TAG_W-1:0] t;
			int q;
			int slot;
			int n;
			t = tag[TAG_W-1:0];
			q = -1;
			n = 0;
			if (op == OP_FLUSH) begin
				flushes++;
				for (int qi = 0; qi < claimed; qi++) begin
					for (int j = 0; j < count[qi]; j++) begin
						slot = qi * QUEUE_DEPTH + (head[qi] + j) % QUEUE_DEPTH;
						push_word(ST_EVENT_OUT, kind_mem[slot], data_mem[slot], qi, 1'b0);
						n++;
					end
					head[qi]  = (head[qi] + count[qi]) % QUEUE_DEPTH;
					count[qi] = 0;
				end
				drained += n;
				if (n == 0)
					push_word(ST_NOTHING, '0, '0, 0, 1'b1);
				else
					expected_words[expected_words.size() - 1].last = 1'b1;
				return;
			end
			enqueues++;
			// unclaimed queues never match, so tag zero at reset claims a queue too
			for (int i = 0; i < claimed; i++) begin
				if (q < 0 && owner[i] == t)
					q = i;
			end
			if (q < 0) begin
				if (claimed >= NUM_SOURCES) begin
					rejected++;
					push_word(ST_NO_QUEUE, '0, '0, 0, 1'b1);
					return;
				end
				q        = claimed;
				owner[q] = t;
				head[q]  = 0;
				count[q] = 0;
				claimed++;
			end
			if (count[q] >= QUEUE_DEPTH) begin
				dropped++;
				push_word(ST_DROP_FULL, '0, '0, q, 1'b1);
				return;
			end
			slot           = q * QUEUE_DEPTH + (head[q] + count[q]) % QUEUE_DEPTH;
			kind_mem[slot] = kind;
			data_mem[slot] = data;
			count[q]++;
			push_word(ST_ACCEPTED, '0, '0, q, 1'b1);
		endfunction

		function automatic void check_word(result_t got);
			result_t exp_w;
			checked++;
			if (expected_words.size() == 0) begin
				$error("unexpected result word: status %0d queue %0d", got.status, got.queue);
				mismatches++;
				return;
			end
			exp_w = expected_words.pop_front();
			if (got.status !== exp_w.status) begin
				$error("status: expected %0d, actual %0d", exp_w.status, got.status);
				mismatches++;
			end
			if (got.kind !== exp_w.kind) begin
				$error("out_kind: expected %0d, actual %0d", exp_w.kind, got.kind);
				mismatches++;
			end
			if (got.payload !== exp_w.payload) begin
				$error("out_payload: expected %h, actual %h", exp_w.payload, got.payload);
				mismatches++;
			end
			if (got.queue !== exp_w.queue) begin
				$error("out_queue: expected %0d, actual %0d", exp_w.queue, got.queue);
				mismatches++;
			end
			if (got.last !== exp_w.last) begin
				$error("last: expected %0d, actual %0d", exp_w.last, got.last);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mseq_in_if  evt_if ();
	mseq_out_if res_if ();

	multi_source_event_queue uut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_if),
		.res    (res_if)
	);

	event_queue_scoreboard sb;

	// sender-to-receiver flags: calm stops all idling, hold_req asks for one
	// long receiver stall
	bit          calm;
	bit          hold_req;
	bit          hold_done;
	int unsigned words_sent;

	// tags that own the four queues once the directed part has run
	logic [SRC_TAG_W-1:0] owners [NUM_SOURCES];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run ends here no matter what if the block hangs.
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// Sample every result word that moves; a word moves on an edge where valid
	// and ready were both high just before it.
	always @(posedge clk) begin
		result_t got;
		if (arst_n && res_if.valid && res_if.ready) begin
			got.status  = status_t'(res_if.status);
			got.kind    = res_if.out_kind;
			got.payload = res_if.out_payload;
			got.queue   = res_if.out_queue;
			got.last    = res_if.last;
			sb.check_word(got);
		end
	end

	// Receiver: take words, drop ready in short random bursts, and once on
	// request hold off long enough that the block backs up into its input.
	initial begin
		res_if.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				res_if.ready <= 1'b0;
				repeat (80) @(posedge clk);
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				res_if.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offer one word and hold it until the block takes it. Unless a random idle
	// drops it first, valid stays high on return so the next word can follow without a gap.
	task automatic send_word(input op_t op, input logic [SRC_TAG_W-1:0] tag,
			input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] data);
		evt_if.valid      <= 1'b1;
		evt_if.op         <= op;
		evt_if.source_tag <= tag;
		evt_if.event_kind <= kind;
		evt_if.payload    <= data;
		@(posedge clk);
		while (!evt_if.ready)
			@(posedge clk);
		sb.note_word(op, tag, kind, data);
		words_sent++;
		// quiet the tail of the run; ask for the long stall once mid-run
		if (words_sent >= 90)
			calm = 1'b1;
		if (words_sent == 45)
			hold_req = 1'b1;
		// keep offering through the long stall so the input backs up
		if (!calm && !(hold_req && !hold_done) && $urandom_range(0, 3) == 0) begin
			evt_if.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic send_enqueue(input logic [SRC_TAG_W-1:0] tag, input logic [KIND_W-1:0] kind,
			input logic [DATA_W-1:0] data);
		send_word(OP_ENQUEUE, tag, kind, data);
	endtask

	task automatic send_flush();
		send_word(OP_FLUSH, SRC_TAG_W'($urandom), KIND_W'($urandom), {$urandom, $urandom});
	endtask

	function automatic logic [DATA_W-1:0] pick_payload();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		logic [SRC_TAG_W-1:0] hot;
		logic [SRC_TAG_W-1:0] tag;
		logic [KIND_W-1:0]    kind;
		int                   run;
		int                   pick;

		sb        = new();
		calm      = 1'b0;
		hold_req  = 1'b0;
		hold_done = 1'b0;
		words_sent = 0;
		owners[0] = 16'h0000;
		owners[1] = 16'hFFFF;
		owners[2] = 16'h1234;
		owners[3] = 16'hA5C3;

		// hold every input at a known value through reset
		arst_n            <= 1'b0;
		evt_if.valid      <= 1'b0;
		evt_if.op         <= OP_ENQUEUE;
		evt_if.source_tag <= '0;
		evt_if.event_kind <= '0;
		evt_if.payload    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		// Flush with nothing stored: one nothing-pending word.
		send_flush();
		// Tag zero claims the first queue, then the extremes of kind and payload.
		send_enqueue(owners[0], 3'd0, '0);
		send_enqueue(owners[1], 3'd7, '1);
		send_enqueue(owners[2], 3'd1, 64'h5555_5555_5555_5555);
		send_enqueue(owners[3], 3'd4, 64'hAAAA_AAAA_AAAA_AAAA);
		// All queues claimed: a new tag is turned away.
		send_enqueue(16'h0001, 3'd2, 64'h0123_4567_89AB_CDEF);
		send_flush();
		// Fill queue zero past its depth; its pointer wraps and the last one drops.
		for (int i = 0; i <= QUEUE_DEPTH; i++)
			send_enqueue(owners[0], KIND_W'(i % 8), {$urandom, $urandom});
		send_flush();

		// Random part: runs of enqueues with random content, mostly aimed at
		// one hot owner so queues fill and drop, each run closed by a flush.
		while (words_sent < 108) begin
			run = $urandom_range(1, 28);
			if (run > int'(110 - words_sent))
				run = int'(110 - words_sent);
			hot = owners[$urandom_range(0, NUM_SOURCES - 1)];
			for (int k = 0; k < run; k++) begin
				pick = $urandom_range(0, 9);
				if (pick < 7)
					tag = hot;
				else if (pick < 9)
					tag = owners[$urandom_range(0, NUM_SOURCES - 1)];
				else
					tag = SRC_TAG_W'($urandom);
				if ($urandom_range(0, 4) == 0)
					kind = KIND_W'($urandom_range(0, 7));
				else
					kind = KIND_W'($urandom_range(1, 4));
				send_enqueue(tag, kind, pick_payload());
			end
			send_flush();
			// a flush right behind a flush finds nothing
			if ($urandom_range(0, 5) == 0)
				send_flush();
		end
		evt_if.valid <= 1'b0;

		// Drain: wait for every expected word, then let the block settle.
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Run covered %0d input words: %0d enqueues, %0d flushes.",
			words_sent, sb.enqueues, sb.flushes);
		$display("Checked %0d result words: %0d drained, %0d dropped full, %0d rejected.",
			sb.checked, sb.drained, sb.dropped, sb.rejected);
		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
